/* hdl/rspp_pkg.sv */
`timescale 1ns / 1ps
// Package for the robot session protocol parser: event and response codes,
// character constants, keyword tables and the structs passed between modules.
// No dependencies.
package rspp_pkg;

   localparam int LENGTH_BITS_DEF = 32;
   localparam logic [15:0] TIMEOUT_RESET = 16'd45;

   typedef enum logic [1:0] {
      OP_CONNECT = 2'd0,
      OP_BYTE    = 2'd1,
      OP_TICK    = 2'd2,
      OP_CLOSE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RSP_LOGIN        = 3'd0,
      RSP_PASSWORD     = 3'd1,
      RSP_OK           = 3'd2,
      RSP_BAD_CHECKSUM = 3'd3,
      RSP_LOGIN_FAILED = 3'd4,
      RSP_SYNTAX_ERROR = 3'd5,
      RSP_TIMEOUT      = 3'd6
   } resp_type;

   typedef struct packed {
      op_type     opcode;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic     valid;
      resp_type response;
      logic     close_after;
   } result_type;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_F     = 8'h46;

   localparam logic [2:0]  PREFIX_LEN = 3'd5;
   // Password magnitude saturates just beyond the signed 32-bit range.
   localparam logic [31:0] MAG_CAP = 32'h8000_0001;
   localparam logic [31:0] MAG_MIN = 32'h8000_0000;
   localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;

   function automatic logic [7:0] robot_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h52; // R
         3'd1:    c = 8'h6F; // o
         3'd2:    c = 8'h62; // b
         3'd3:    c = 8'h6F; // o
         3'd4:    c = 8'h74; // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] info_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h4E; // N
         2'd1:    c = 8'h46; // F
         2'd2:    c = 8'h4F; // O
         default: c = CH_SPACE;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] foto_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h4F; // O
         2'd1:    c = 8'h54; // T
         2'd2:    c = 8'h4F; // O
         default: c = CH_SPACE;
      endcase
      return c;
   endfunction

endpackage

/* hdl/robot_session_protocol_parser_core.sv */
`timescale 1ns / 1ps
// Top level of the robot session protocol parser: input register, session
// engine, result register and timeout register. Depends on rspp_pkg,
// rspp_in_stage and rspp_engine.

// The parser takes one event transaction (connect, received byte, tick or peer
// close) in every clock cycle unless the response side stalls it, and answers
// with at most one response. An event is captured in the input register,
// processed by the session engine once the result register is free or being
// emptied, and its response is registered in the result register that drives
// the rsp_ port; the engine's state update is what sets that rate. A response
// that waits on rsp_ready stalls the input only once both registers are full.
// The timeout limit is written through the csr_ port, which is always ready,
// and should only be changed while no transaction is in flight.
module robot_session_protocol_parser_core #(
   parameter int LENGTH_BITS = rspp_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_response,
   output logic        rsp_close_after,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_limit
);

   rspp_pkg::item_type   req_item;
   rspp_pkg::item_type   item;
   rspp_pkg::result_type result;
   logic                 advance;
   logic                 fire;

   logic [15:0] timeout_limit_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_response_ff;
   logic        rsp_close_ff;

   assign req_item.opcode  = rspp_pkg::op_type'(req_opcode);
   assign req_item.rx_byte = req_rx_byte;

   // The engine may run whenever the result register is free or being emptied.
   assign advance = !rsp_valid_ff || rsp_ready;

   rspp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .advance   (advance),
      .fire      (fire),
      .item      (item)
   );

   rspp_engine #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (item),
      .timeout_limit (timeout_limit_ff),
      .result        (result)
   );

   assign rsp_valid_in = advance ? result.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         timeout_limit_ff <= rspp_pkg::TIMEOUT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            timeout_limit_ff <= csr_timeout_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_response_ff <= 3'(result.response);
         rsp_close_ff    <= result.close_after;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_response    = rsp_response_ff;
   assign rsp_close_after = rsp_close_ff;

endmodule

/* hdl/rspp_in_stage.sv */
`timescale 1ns / 1ps
// Input register of the parser: holds one accepted event until the session
// engine consumes it. Depends on rspp_pkg.
module rspp_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rspp_pkg::item_type req_item,
   input  logic               advance,
   output logic               fire,
   output rspp_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   rspp_pkg::item_type item_ff;

   // The slot frees up whenever its transaction moves on to the engine.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;
   assign fire      = valid_ff && advance;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

/* hdl/rspp_engine.sv */
`timescale 1ns / 1ps
// Session engine: protocol state registers and the combinational update that
// turns one event into at most one response. Depends on rspp_pkg.
module rspp_engine #(
   parameter int LENGTH_BITS = rspp_pkg::LENGTH_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  rspp_pkg::item_type   item,
   input  logic [15:0]          timeout_limit,
   output rspp_pkg::result_type result
);

   typedef enum logic [9:0] {
      PH_CLOSED    = 10'b00_0000_0001,
      PH_LOGIN     = 10'b00_0000_0010,
      PH_PASS      = 10'b00_0000_0100,
      PH_CMD       = 10'b00_0000_1000,
      PH_KW_INFO   = 10'b00_0001_0000,
      PH_INFO_LINE = 10'b00_0010_0000,
      PH_KW_FOTO   = 10'b00_0100_0000,
      PH_LENGTH    = 10'b00_1000_0000,
      PH_PAYLOAD   = 10'b01_0000_0000,
      PH_TRAILER   = 10'b10_0000_0000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [31:0]            login_sum_ff, login_sum_in;
   logic [2:0]             prefix_idx_ff, prefix_idx_in;
   logic                   prefix_ok_ff, prefix_ok_in;
   logic                   prev_cr_ff, prev_cr_in;
   logic [31:0]            pw_value_ff, pw_value_in;
   logic                   pw_started_ff, pw_started_in;
   logic                   pw_neg_ff, pw_neg_in;
   logic                   pw_digit_ff, pw_digit_in;
   logic                   pw_end_ff, pw_end_in;
   logic [1:0]             kw_idx_ff, kw_idx_in;
   logic [LENGTH_BITS-1:0] frame_len_ff, frame_len_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [39:0]            payload_sum_ff, payload_sum_in;
   logic [31:0]            trailer_ff, trailer_in;
   logic [1:0]             trailer_idx_ff, trailer_idx_in;
   logic [15:0]            elapsed_ff, elapsed_in;

   logic [7:0]             b;
   logic                   is_digit;
   logic                   is_space;
   logic                   line_end;
   logic [3:0]             digit_val;
   logic [35:0]            pw_product;
   logic [31:0]            pw_result;
   logic [LENGTH_BITS-1:0] len_next;
   logic [7:0]             kw_char;

   assign b         = item.rx_byte;
   assign is_digit  = (b >= rspp_pkg::CH_ZERO) && (b <= rspp_pkg::CH_NINE);
   assign is_space  = b inside {[rspp_pkg::CH_TAB:rspp_pkg::CH_CR], rspp_pkg::CH_SPACE};
   assign line_end  = prev_cr_ff && (b == rspp_pkg::CH_LF);
   assign digit_val = b[3:0];
   assign kw_char   = (phase_ff == PH_KW_INFO) ? rspp_pkg::info_char(kw_idx_ff)
                                               : rspp_pkg::foto_char(kw_idx_ff);

   // Times ten as two shifts and an add.
   assign pw_product = {1'b0, pw_value_ff, 3'b000} + {3'b000, pw_value_ff, 1'b0}
                       + {32'd0, digit_val};
   assign len_next   = (frame_len_ff << 3) + (frame_len_ff << 1)
                       + {{(LENGTH_BITS-4){1'b0}}, digit_val};

   // Signed value of the parsed password as a 32-bit pattern.
   always_comb begin
      if (!pw_digit_ff) begin
         pw_result = 32'd0;
      end else if (pw_neg_ff) begin
         pw_result = (pw_value_ff > rspp_pkg::MAG_MIN) ? rspp_pkg::MAG_MIN
                                                       : (32'd0 - pw_value_ff);
      end else begin
         pw_result = (pw_value_ff > rspp_pkg::MAG_MAX) ? rspp_pkg::MAG_MAX : pw_value_ff;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      login_sum_in   = login_sum_ff;
      prefix_idx_in  = prefix_idx_ff;
      prefix_ok_in   = prefix_ok_ff;
      prev_cr_in     = prev_cr_ff;
      pw_value_in    = pw_value_ff;
      pw_started_in  = pw_started_ff;
      pw_neg_in      = pw_neg_ff;
      pw_digit_in    = pw_digit_ff;
      pw_end_in      = pw_end_ff;
      kw_idx_in      = kw_idx_ff;
      frame_len_in   = frame_len_ff;
      bytes_left_in  = bytes_left_ff;
      payload_sum_in = payload_sum_ff;
      trailer_in     = trailer_ff;
      trailer_idx_in = trailer_idx_ff;
      elapsed_in     = elapsed_ff;
      result.valid       = 1'b0;
      result.response    = rspp_pkg::RSP_OK;
      result.close_after = 1'b0;

      if (fire) begin
         case (item.opcode)
            rspp_pkg::OP_CONNECT: begin
               phase_in      = PH_LOGIN;
               login_sum_in  = 32'd0;
               prefix_idx_in = 3'd0;
               prefix_ok_in  = 1'b1;
               prev_cr_in    = 1'b0;
               pw_value_in   = 32'd0;
               pw_started_in = 1'b0;
               pw_neg_in     = 1'b0;
               pw_digit_in   = 1'b0;
               pw_end_in     = 1'b0;
               elapsed_in    = 16'd0;
               result.valid    = 1'b1;
               result.response = rspp_pkg::RSP_LOGIN;
            end
            rspp_pkg::OP_CLOSE: begin
               phase_in = PH_CLOSED;
            end
            rspp_pkg::OP_TICK: begin
               if (phase_ff != PH_CLOSED) begin
                  if (elapsed_ff != 16'hFFFF) begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
                  if (elapsed_in > timeout_limit) begin
                     phase_in           = PH_CLOSED;
                     result.valid       = 1'b1;
                     result.response    = rspp_pkg::RSP_TIMEOUT;
                     result.close_after = 1'b1;
                  end
               end
            end
            rspp_pkg::OP_BYTE: begin
               case (phase_ff)
                  PH_LOGIN: begin
                     if (line_end) begin
                        // The CR was already added to the sum; take it out again.
                        login_sum_in    = login_sum_ff - 32'd13;
                        prefix_ok_in    = prefix_ok_ff && (prefix_idx_ff == rspp_pkg::PREFIX_LEN);
                        prev_cr_in      = 1'b0;
                        phase_in        = PH_PASS;
                        result.valid    = 1'b1;
                        result.response = rspp_pkg::RSP_PASSWORD;
                     end else begin
                        login_sum_in = login_sum_ff + {{24{b[7]}}, b};
                        if (prefix_idx_ff < rspp_pkg::PREFIX_LEN) begin
                           if (b == rspp_pkg::robot_char(prefix_idx_ff)) begin
                              prefix_idx_in = prefix_idx_ff + 3'd1;
                           end else begin
                              prefix_ok_in = 1'b0;
                           end
                        end
                        prev_cr_in = (b == rspp_pkg::CH_CR);
                     end
                  end
                  PH_PASS: begin
                     if (line_end) begin
                        prev_cr_in   = 1'b0;
                        result.valid = 1'b1;
                        if (!prefix_ok_ff || (pw_result != login_sum_ff)) begin
                           phase_in           = PH_CLOSED;
                           result.response    = rspp_pkg::RSP_LOGIN_FAILED;
                           result.close_after = 1'b1;
                        end else begin
                           phase_in        = PH_CMD;
                           result.response = rspp_pkg::RSP_OK;
                        end
                     end else begin
                        prev_cr_in = (b == rspp_pkg::CH_CR);
                        if (!pw_end_ff) begin
                           if (!pw_started_ff && is_space) begin
                              pw_started_in = 1'b0;
                           end else if (!pw_started_ff &&
                                        (b == rspp_pkg::CH_PLUS || b == rspp_pkg::CH_MINUS)) begin
                              pw_started_in = 1'b1;
                              pw_neg_in     = (b == rspp_pkg::CH_MINUS);
                           end else if (!is_digit) begin
                              pw_end_in = 1'b1;
                           end else begin
                              pw_started_in = 1'b1;
                              pw_digit_in   = 1'b1;
                              if (pw_value_ff < rspp_pkg::MAG_CAP) begin
                                 pw_value_in = (pw_product > {4'd0, rspp_pkg::MAG_MIN})
                                               ? rspp_pkg::MAG_CAP : pw_product[31:0];
                              end
                           end
                        end
                     end
                  end
                  PH_CMD: begin
                     kw_idx_in = 2'd0;
                     if (b == rspp_pkg::CH_I) begin
                        phase_in = PH_KW_INFO;
                     end else if (b == rspp_pkg::CH_F) begin
                        phase_in = PH_KW_FOTO;
                     end else begin
                        phase_in           = PH_CLOSED;
                        result.valid       = 1'b1;
                        result.response    = rspp_pkg::RSP_SYNTAX_ERROR;
                        result.close_after = 1'b1;
                     end
                  end
                  PH_KW_INFO, PH_KW_FOTO: begin
                     if (b != kw_char) begin
                        phase_in           = PH_CLOSED;
                        result.valid       = 1'b1;
                        result.response    = rspp_pkg::RSP_SYNTAX_ERROR;
                        result.close_after = 1'b1;
                     end else begin
                        kw_idx_in = kw_idx_ff + 2'd1;
                        if (kw_idx_ff == 2'd3) begin
                           prev_cr_in   = 1'b0;
                           frame_len_in = '0;
                           phase_in     = (phase_ff == PH_KW_INFO) ? PH_INFO_LINE : PH_LENGTH;
                        end
                     end
                  end
                  PH_INFO_LINE: begin
                     if (line_end) begin
                        prev_cr_in      = 1'b0;
                        phase_in        = PH_CMD;
                        result.valid    = 1'b1;
                        result.response = rspp_pkg::RSP_OK;
                     end else begin
                        prev_cr_in = (b == rspp_pkg::CH_CR);
                     end
                  end
                  PH_LENGTH: begin
                     if (is_digit) begin
                        frame_len_in = len_next;
                     end else if (b == rspp_pkg::CH_SPACE) begin
                        bytes_left_in  = frame_len_ff;
                        payload_sum_in = 40'd0;
                        trailer_in     = 32'd0;
                        trailer_idx_in = 2'd0;
                        phase_in       = (frame_len_ff == '0) ? PH_TRAILER : PH_PAYLOAD;
                     end else begin
                        phase_in           = PH_CLOSED;
                        result.valid       = 1'b1;
                        result.response    = rspp_pkg::RSP_SYNTAX_ERROR;
                        result.close_after = 1'b1;
                     end
                  end
                  PH_PAYLOAD: begin
                     payload_sum_in = payload_sum_ff + {32'd0, b};
                     bytes_left_in  = bytes_left_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                     if (bytes_left_in == '0) begin
                        phase_in = PH_TRAILER;
                     end
                  end
                  PH_TRAILER: begin
                     trailer_in     = {trailer_ff[23:0], b};
                     trailer_idx_in = trailer_idx_ff + 2'd1;
                     if (trailer_idx_ff == 2'd3) begin
                        phase_in        = PH_CMD;
                        result.valid    = 1'b1;
                        result.response = (payload_sum_ff == {8'd0, trailer_in})
                                          ? rspp_pkg::RSP_OK : rspp_pkg::RSP_BAD_CHECKSUM;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CLOSED;
         prefix_idx_ff  <= 3'd0;
         prefix_ok_ff   <= 1'b1;
         prev_cr_ff     <= 1'b0;
         pw_started_ff  <= 1'b0;
         pw_neg_ff      <= 1'b0;
         pw_digit_ff    <= 1'b0;
         pw_end_ff      <= 1'b0;
         kw_idx_ff      <= 2'd0;
         trailer_idx_ff <= 2'd0;
         elapsed_ff     <= 16'd0;
      end else begin
         phase_ff       <= phase_in;
         prefix_idx_ff  <= prefix_idx_in;
         prefix_ok_ff   <= prefix_ok_in;
         prev_cr_ff     <= prev_cr_in;
         pw_started_ff  <= pw_started_in;
         pw_neg_ff      <= pw_neg_in;
         pw_digit_ff    <= pw_digit_in;
         pw_end_ff      <= pw_end_in;
         kw_idx_ff      <= kw_idx_in;
         trailer_idx_ff <= trailer_idx_in;
         elapsed_ff     <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      login_sum_ff   <= login_sum_in;
      pw_value_ff    <= pw_value_in;
      frame_len_ff   <= frame_len_in;
      bytes_left_ff  <= bytes_left_in;
      payload_sum_ff <= payload_sum_in;
      trailer_ff     <= trailer_in;
   end

   a_close_ends_session: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.close_after) |=> (phase_ff == PH_CLOSED))
      else $error("session still open after a closing response");

   a_connect_restarts: assert property (@(posedge clock) disable iff (reset)
      (fire && item.opcode == rspp_pkg::OP_CONNECT)
      |=> (phase_ff == PH_LOGIN && login_sum_ff == 32'd0 && elapsed_ff == 16'd0))
      else $error("connect did not restart the session");

   a_prefix_bound: assert property (@(posedge clock) disable iff (reset)
      prefix_idx_ff <= rspp_pkg::PREFIX_LEN)
      else $error("login prefix index ran past the prefix");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (bytes_left_ff != '0))
      else $error("payload phase with no bytes left");

   a_result_needs_event: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> fire)
      else $error("response raised without a transaction");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for robot_session_protocol_parser_core: drives connect, byte, tick
// and close events and checks every response against a session model held in a scoreboard.
// Depends on rspp_pkg and the core RTL.
module tb_top;

   typedef enum logic [3:0] {
      ST_CLOSED, ST_LOGIN, ST_PASSWORD, ST_COMMAND, ST_INFO_KEY, ST_INFO_LINE,
      ST_FOTO_KEY, ST_LENGTH, ST_PAYLOAD, ST_CHECKSUM
   } phase_type;

   typedef struct packed {
      rspp_pkg::resp_type response;
      logic               close_after;
   } answer_type;

   // Tracks the session as the block should see it and queues the answers it owes.
   class session_scoreboard;
      answer_type  pending_answers[$];
      int          fail_count = 0;
      logic [15:0] limit = rspp_pkg::TIMEOUT_RESET;
      string       robot_word = "Robot";
      string       info_word = "NFO ";
      string       foto_word = "OTO ";
      phase_type   phase;
      logic [31:0] login_sum;
      logic [2:0]  prefix_index;
      logic        prefix_ok;
      logic        prev_cr;
      logic [31:0] pw_mag;
      logic        pw_started, pw_neg, pw_digit, pw_end;
      logic [2:0]  kw_index;
      logic [31:0] frame_len;
      logic [31:0] bytes_left;
      logic [39:0] payload_sum;
      logic [31:0] trailer;
      logic [2:0]  trailer_idx;
      logic [15:0] ticks;

      function new();
         clear_session();
      endfunction

      function void clear_session();
         phase = ST_CLOSED;
         login_sum = '0;
         prefix_index = '0;
         prefix_ok = 1'b1;
         prev_cr = 1'b0;
         pw_mag = '0;
         {pw_started, pw_neg, pw_digit, pw_end} = '0;
         kw_index = '0;
         frame_len = '0;
         bytes_left = '0;
         payload_sum = '0;
         trailer = '0;
         trailer_idx = '0;
         ticks = '0;
      endfunction

      function void add_answer(rspp_pkg::resp_type r, logic c);
         answer_type a;
         a.response = r;
         a.close_after = c;
         pending_answers = {pending_answers, a};
         if (c) phase = ST_CLOSED;
      endfunction

      // Applies one accepted event to the session as the block sees it.
      function void note_event(rspp_pkg::op_type op, logic [7:0] b);
         bit          line_end;
         bit          digit;
         logic [63:0] wide;
         logic [31:0] value;
         logic [7:0]  want_char;
         if (op == rspp_pkg::OP_CONNECT) begin
            clear_session();
            phase = ST_LOGIN;
            add_answer(rspp_pkg::RSP_LOGIN, 1'b0);
            return;
         end
         if (op == rspp_pkg::OP_CLOSE) begin
            phase = ST_CLOSED;
            return;
         end
         if (phase == ST_CLOSED) return;
         if (op == rspp_pkg::OP_TICK) begin
            if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            if (ticks > limit) add_answer(rspp_pkg::RSP_TIMEOUT, 1'b1);
            return;
         end
         line_end = prev_cr && b == rspp_pkg::CH_LF;
         digit = b >= rspp_pkg::CH_ZERO && b <= rspp_pkg::CH_NINE;
         case (phase)
            ST_LOGIN: begin
               if (line_end) begin
                  // The CR was summed with the rest of the line, so take it back out.
                  login_sum = login_sum - 32'd13;
                  prefix_ok = prefix_ok && prefix_index == rspp_pkg::PREFIX_LEN;
                  prev_cr = 1'b0;
                  phase = ST_PASSWORD;
                  add_answer(rspp_pkg::RSP_PASSWORD, 1'b0);
               end else begin
                  login_sum = login_sum + {{24{b[7]}}, b};
                  if (prefix_index < rspp_pkg::PREFIX_LEN) begin
                     if (b == robot_word[prefix_index]) prefix_index = prefix_index + 3'd1;
                     else prefix_ok = 1'b0;
                  end
                  prev_cr = b == rspp_pkg::CH_CR;
               end
            end
            ST_PASSWORD: begin
               if (line_end) begin
                  prev_cr = 1'b0;
                  if (!pw_digit) value = '0;
                  else if (pw_neg) value = (pw_mag > rspp_pkg::MAG_MIN) ? rspp_pkg::MAG_MIN
                                                                        : 32'd0 - pw_mag;
                  else value = (pw_mag > rspp_pkg::MAG_MAX) ? rspp_pkg::MAG_MAX : pw_mag;
                  if (!prefix_ok || value != login_sum) begin
                     add_answer(rspp_pkg::RSP_LOGIN_FAILED, 1'b1);
                  end else begin
                     phase = ST_COMMAND;
                     add_answer(rspp_pkg::RSP_OK, 1'b0);
                  end
               end else begin
                  // Leading whitespace is skipped until a sign or digit has been seen.
                  if (!pw_end && (pw_started || !(b == rspp_pkg::CH_SPACE ||
                                  (b >= rspp_pkg::CH_TAB && b <= rspp_pkg::CH_CR)))) begin
                     if (!pw_started && (b == rspp_pkg::CH_PLUS || b == rspp_pkg::CH_MINUS)) begin
                        pw_started = 1'b1;
                        pw_neg = b == rspp_pkg::CH_MINUS;
                     end else if (!digit) begin
                        pw_end = 1'b1;
                     end else begin
                        pw_started = 1'b1;
                        pw_digit = 1'b1;
                        if (pw_mag < rspp_pkg::MAG_CAP) begin
                           wide = {32'd0, pw_mag} * 64'd10 + {56'd0, b - rspp_pkg::CH_ZERO};
                           pw_mag = (wide > 64'h8000_0000) ? rspp_pkg::MAG_CAP : wide[31:0];
                        end
                     end
                  end
                  prev_cr = b == rspp_pkg::CH_CR;
               end
            end
            ST_COMMAND: begin
               kw_index = '0;
               if (b == rspp_pkg::CH_I) phase = ST_INFO_KEY;
               else if (b == rspp_pkg::CH_F) phase = ST_FOTO_KEY;
               else add_answer(rspp_pkg::RSP_SYNTAX_ERROR, 1'b1);
            end
            ST_INFO_KEY, ST_FOTO_KEY: begin
               want_char = (phase == ST_INFO_KEY) ? info_word[kw_index[1:0]]
                                                  : foto_word[kw_index[1:0]];
               if (b != want_char) begin
                  add_answer(rspp_pkg::RSP_SYNTAX_ERROR, 1'b1);
               end else begin
                  kw_index = kw_index + 3'd1;
                  if (kw_index >= 3'd4) begin
                     kw_index = '0;
                     prev_cr = 1'b0;
                     frame_len = '0;
                     phase = (phase == ST_INFO_KEY) ? ST_INFO_LINE : ST_LENGTH;
                  end
               end
            end
            ST_INFO_LINE: begin
               if (line_end) begin
                  prev_cr = 1'b0;
                  phase = ST_COMMAND;
                  add_answer(rspp_pkg::RSP_OK, 1'b0);
               end else begin
                  prev_cr = b == rspp_pkg::CH_CR;
               end
            end
            ST_LENGTH: begin
               if (digit) begin
                  frame_len = frame_len * 32'd10 + {24'd0, b - rspp_pkg::CH_ZERO};
               end else if (b != rspp_pkg::CH_SPACE) begin
                  add_answer(rspp_pkg::RSP_SYNTAX_ERROR, 1'b1);
               end else begin
                  bytes_left = frame_len;
                  payload_sum = '0;
                  trailer = '0;
                  trailer_idx = '0;
                  phase = (frame_len == 0) ? ST_CHECKSUM : ST_PAYLOAD;
               end
            end
            ST_PAYLOAD: begin
               payload_sum = payload_sum + {32'd0, b};
               bytes_left = bytes_left - 32'd1;
               if (bytes_left == 0) phase = ST_CHECKSUM;
            end
            ST_CHECKSUM: begin
               trailer = {trailer[23:0], b};
               trailer_idx = trailer_idx + 3'd1;
               if (trailer_idx >= 3'd4) begin
                  phase = ST_COMMAND;
                  add_answer(payload_sum == {8'd0, trailer} ? rspp_pkg::RSP_OK
                                                            : rspp_pkg::RSP_BAD_CHECKSUM, 1'b0);
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report(input string what);
         $display("[%0t] mismatch: %s", $time, what);
         fail_count++;
      endtask

      task check_answer(input logic [2:0] got_resp, input logic got_close);
         answer_type want;
         if (pending_answers.size() == 0) begin
            report($sformatf("response %0d with none outstanding", got_resp));
            return;
         end
         want = pending_answers.pop_front();
         if (got_resp !== want.response)
            report($sformatf("response %0d, expected %s", got_resp, want.response.name()));
         if (got_close !== want.close_after)
            report($sformatf("close_after %b, expected %b after %s", got_close,
                             want.close_after, want.response.name()));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = rspp_pkg::OP_CONNECT;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_response;
   logic        rsp_close_after;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_timeout_limit = rspp_pkg::TIMEOUT_RESET;

   session_scoreboard sb = new();
   bit full_speed = 1'b0;
   int tick_pct = 0;
   int sent_items = 0;

   robot_session_protocol_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_response      (rsp_response),
      .rsp_close_after   (rsp_close_after),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_limit (csr_timeout_limit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("robot_session_protocol_parser_core regression: fail");
      $finish;
   end

   function automatic int draw_wait();
      return full_speed ? 0 : int'($urandom_range(0, 17));
   endfunction

   function automatic logic [7:0] line_filler(input logic [7:0] prev);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      // Keep the line open: a LF straight after a CR would end it early.
      if (prev == rspp_pkg::CH_CR && b == rspp_pkg::CH_LF) b = rspp_pkg::CH_SPACE;
      return b;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_answer(rsp_response, rsp_close_after);
   end

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Valid is left high after acceptance; the next call either replaces the payload
   // in the same step or lowers valid for its gap.
   task automatic send_event(input rspp_pkg::op_type op, input logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_event(op, b);
      sent_items++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < tick_pct)
         send_event(rspp_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      send_event(rspp_pkg::OP_BYTE, b);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_crlf();
      send_byte(rspp_pkg::CH_CR);
      send_byte(rspp_pkg::CH_LF);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_answers.size() != 0);
   endtask

   task automatic write_limit(input logic [15:0] value);
      drain_answers();
      // Events that cause no response may still be inside the pipeline.
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_timeout_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.limit = value;
   endtask

   task automatic send_login(output logic [31:0] sum);
      string      login_text;
      logic [7:0] b, prev;
      int         i;
      case ($urandom_range(0, 9))
         0: login_text = "Rob";
         1: login_text = "Rabot";
         default: login_text = "Robot";
      endcase
      sum = '0;
      prev = '0;
      for (i = 0; i < login_text.len(); i++) begin
         b = login_text[i];
         sum = sum + {{24{b[7]}}, b};
         send_byte(b);
      end
      repeat ($urandom_range(0, 12)) begin
         b = line_filler(prev);
         sum = sum + {{24{b[7]}}, b};
         send_byte(b);
         prev = b;
      end
      send_crlf();
   endtask

   task automatic send_password(input logic [31:0] sum);
      longint     mag;
      string      text;
      bit         neg;
      logic [7:0] ws, prev;
      neg = sum[31];
      mag = longint'($signed(sum));
      if (neg) mag = -mag;
      if ($urandom_range(0, 7) == 0) mag += longint'(1 + $urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) mag = 64'd99_999_999_999;
      text = $sformatf("%0d", mag);
      if ($urandom_range(0, 3) == 0) text = {"00", text};
      if (neg) text = {"-", text};
      else if ($urandom_range(0, 3) == 0) text = {"+", text};
      if ($urandom_range(0, 19) == 0) begin
         if (neg) text = "-";
         else text = "";
      end
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 0) text = {text, "x7"};
         else text = {text, " 12"};
      end
      prev = '0;
      repeat ($urandom_range(0, 3)) begin
         ws = ($urandom_range(0, 5) == 0) ? rspp_pkg::CH_SPACE : 8'($urandom_range(9, 13));
         if (prev == rspp_pkg::CH_CR && ws == rspp_pkg::CH_LF) ws = rspp_pkg::CH_SPACE;
         send_byte(ws);
         prev = ws;
      end
      send_text(text);
      send_crlf();
   endtask

   task automatic send_info();
      logic [7:0] b, prev;
      send_text("INFO ");
      prev = '0;
      repeat ($urandom_range(0, 20)) begin
         b = line_filler(prev);
         send_byte(b);
         prev = b;
      end
      send_crlf();
   endtask

   task automatic send_photo();
      longint      count;
      string       len_text;
      logic [39:0] total;
      logic [31:0] trailer_word;
      logic [7:0]  b;
      int          pick, k;
      pick = $urandom_range(0, 39);
      // Lengths past 32 bits wrap, so these two carry one payload byte and none.
      if (pick == 0) begin
         len_text = "4294967297";
         count = 1;
      end else if (pick == 1) begin
         len_text = "4294967296";
         count = 0;
      end else begin
         count = (pick < 4) ? longint'($urandom_range(17, 300))
                            : longint'($urandom_range(0, 16));
         len_text = $sformatf("%0d", count);
         if (pick % 7 == 0) len_text = {"0", len_text};
      end
      send_text("FOTO ");
      send_text(len_text);
      send_byte(rspp_pkg::CH_SPACE);
      total = '0;
      repeat (count) begin
         b = 8'($urandom_range(0, 255));
         total = total + {32'd0, b};
         send_byte(b);
      end
      trailer_word = total[31:0];
      if ($urandom_range(0, 3) == 0) trailer_word ^= 32'd1 << $urandom_range(0, 31);
      for (k = 3; k >= 0; k--) send_byte(trailer_word[8 * k +: 8]);
   endtask

   task automatic send_broken_command();
      logic [7:0] b;
      case ($urandom_range(0, 2))
         0: begin
            b = 8'($urandom_range(0, 255));
            if (b == rspp_pkg::CH_I || b == rspp_pkg::CH_F) b = rspp_pkg::CH_LF;
            send_byte(b);
         end
         1: begin
            if ($urandom_range(0, 1) == 0) send_text("INFX");
            else send_text("FOTA");
         end
         default: begin
            send_text("FOTO 12");
            b = 8'($urandom_range(0, 255));
            if (b == rspp_pkg::CH_SPACE || (b >= rspp_pkg::CH_ZERO && b <= rspp_pkg::CH_NINE))
               b = 8'h78;
            send_byte(b);
         end
      endcase
   endtask

   task automatic run_session();
      logic [31:0] sum;
      send_event(rspp_pkg::OP_CONNECT, 8'($urandom_range(0, 255)));
      send_login(sum);
      send_password(sum);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: send_info();
            11: send_broken_command();
            default: send_photo();
         endcase
      end
      case ($urandom_range(0, 3))
         0: send_event(rspp_pkg::OP_CLOSE, 8'($urandom_range(0, 255)));
         1: repeat ($urandom_range(1, 10))
               send_event(rspp_pkg::OP_TICK, 8'($urandom_range(0, 255)));
         default: begin
         end
      endcase
   endtask

   initial begin
      int next_limit_at;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Events while closed are ignored, a second connect restarts the session,
      // and a login line too short for the prefix fails at the password.
      send_event(rspp_pkg::OP_BYTE, 8'hFF);
      send_event(rspp_pkg::OP_TICK, 8'h00);
      send_event(rspp_pkg::OP_CONNECT, 8'h00);
      send_event(rspp_pkg::OP_CONNECT, 8'hA5);
      send_text("Rob");
      send_crlf();
      send_crlf();
      send_event(rspp_pkg::OP_CLOSE, 8'h00);
      send_event(rspp_pkg::OP_CLOSE, 8'hFF);
      send_event(rspp_pkg::OP_BYTE, 8'h52);

      // A short run of ticks stays below the top limits; a limit of one times out
      // on the second tick.
      write_limit(16'hFFFF);
      full_speed = 1'b1;
      send_event(rspp_pkg::OP_CONNECT, 8'h00);
      repeat (40) send_event(rspp_pkg::OP_TICK, 8'h00);
      write_limit(16'hFFFE);
      send_event(rspp_pkg::OP_TICK, 8'h00);
      write_limit(16'd1);
      send_event(rspp_pkg::OP_CONNECT, 8'h00);
      send_event(rspp_pkg::OP_TICK, 8'h00);
      send_event(rspp_pkg::OP_TICK, 8'h00);

      tick_pct = 3;
      sent_items = 0;
      next_limit_at = 0;
      while (sent_items < 1500) begin
         if (sent_items >= next_limit_at) begin
            case ($urandom_range(0, 5))
               0: write_limit(16'd1);
               1: write_limit(16'hFFFF);
               2: write_limit(rspp_pkg::TIMEOUT_RESET);
               5: write_limit(16'($urandom_range(1, 65535)));
               default: write_limit(16'($urandom_range(2, 8)));
            endcase
            next_limit_at += 250;
         end
         full_speed = $urandom_range(0, 3) == 0;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(5, 30))
               send_event(rspp_pkg::op_type'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
         end else begin
            run_session();
         end
         if ($urandom_range(0, 24) == 0) drain_answers();
      end

      drain_answers();
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("robot_session_protocol_parser_core regression: pass");
      end else begin
         $display("robot_session_protocol_parser_core regression: fail");
      end
      $finish;
   end

endmodule
